@@ hdl/sqd_pkg.sv @@
// Package for the stack/queue/deque block: sizes, operation and status codes,
// beat structs and ring-slot helpers. No dependencies.
`default_nettype none
package sqd_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);
  localparam int unsigned SW         = CW + 1;

  typedef logic [AW-1:0]         slot_t;
  typedef logic [CW-1:0]         cnt_t;
  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [3:0] {
    KIND_PUSH_FRONT = 4'd0,
    KIND_PUSH_BACK  = 4'd1,
    KIND_POP_FRONT  = 4'd2,
    KIND_PEEK_FIRST = 4'd3,
    KIND_PEEK_LAST  = 4'd4,
    KIND_CONTAINS   = 4'd5,
    KIND_CLEAR      = 4'd6,
    KIND_REWIND     = 4'd7,
    KIND_NEXT       = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_NO_NEXT = 2'd3
  } status_e;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] data_word;
  } req_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [1:0]  status;
    logic        flag;
    logic [4:0]  count;
  } res_t;

  // (a + b) mod DEPTH, with a < DEPTH and b <= DEPTH
  function automatic slot_t slot_add(slot_t a, cnt_t b);
    logic [SW-1:0] s;
    s = SW'(a) + SW'(b);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return slot_t'(s);
  endfunction

  // distance from head to slot around the ring
  function automatic slot_t slot_dist(slot_t slot, slot_t head);
    return slot_add(slot, cnt_t'(DEPTH) - cnt_t'(head));
  endfunction

endpackage
`default_nettype wire

@@ hdl/sqd_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module sqd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hdl/stack_queue_deque.sv @@
// Bounded deque/stack/queue of words held in a ring in one synchronous RAM.
// Depends on sqd_pkg and sqd_ram.
// Push, clear, rewind and errors end in the execute state; pop, peek, next
// add a RAM read state; contains reads one element per step. One op at a time.
// Result beat shown for one cycle on done_o; the next op may start meanwhile.
// Reset: empty, head at slot 0, iterator before first element; RAM not cleared.
`default_nettype none
module stack_queue_deque (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire sqd_pkg::req_t req_i,
  output logic               busy_o,
  output logic               done_o,
  output sqd_pkg::res_t      res_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_SCAN = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  sqd_pkg::req_t   req_q;
  sqd_pkg::slot_t  head_q, head_d;
  sqd_pkg::cnt_t   count_q, count_d;
  sqd_pkg::slot_t  cur_q, cur_d;
  logic            before_q, before_d;
  sqd_pkg::cnt_t   idx_q, idx_d;
  logic            flag_q, flag_d;
  logic            done_q, done_d;
  sqd_pkg::res_t   res_q, res_d;

  logic            we, re;
  sqd_pkg::slot_t  waddr, raddr;
  sqd_pkg::word_t  wdata, rdata;

  logic            accept;
  logic            full, empty;
  sqd_pkg::cnt_t   new_pos;
  logic            follows, follows_after;
  sqd_pkg::cnt_t   idx_nxt;
  sqd_pkg::word_t  key;

  assign accept = start_i && !busy_o;
  assign full   = (count_q == sqd_pkg::cnt_t'(sqd_pkg::DEPTH));
  assign empty  = (count_q == '0);
  assign key    = sqd_pkg::word_t'(req_q.data_word);

  assign new_pos = before_q ? '0
                 : sqd_pkg::cnt_t'(sqd_pkg::slot_dist(cur_q, head_q)) + 1'b1;
  assign follows       = new_pos < count_q;
  assign follows_after = (new_pos + 1'b1) < count_q;
  assign idx_nxt       = idx_q + 1'b1;

  sqd_ram #(
    .WIDTH (sqd_pkg::DATA_WIDTH),
    .DEPTH (sqd_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    cur_d    = cur_q;
    before_d = before_q;
    idx_d    = idx_q;
    flag_d   = flag_q;
    done_d   = 1'b0;
    res_d    = res_q;
    we       = 1'b0;
    waddr    = head_q;
    wdata    = key;
    re       = 1'b0;
    raddr    = head_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_d.read_word = '0;
        res_d.status    = sqd_pkg::STAT_OK;
        res_d.flag      = 1'b0;
        flag_d          = 1'b0;
        state_d         = ST_IDLE;
        done_d          = 1'b1;
        unique case (req_q.kind) inside
          sqd_pkg::KIND_PUSH_FRONT: begin
            if (full) begin
              res_d.status = sqd_pkg::STAT_FULL;
            end else begin
              head_d  = sqd_pkg::slot_add(head_q, sqd_pkg::cnt_t'(sqd_pkg::DEPTH - 1));
              we      = 1'b1;
              waddr   = head_d;
              count_d = count_q + 1'b1;
            end
          end
          sqd_pkg::KIND_PUSH_BACK: begin
            if (full) begin
              res_d.status = sqd_pkg::STAT_FULL;
            end else begin
              we      = 1'b1;
              waddr   = sqd_pkg::slot_add(head_q, count_q);
              count_d = count_q + 1'b1;
            end
          end
          sqd_pkg::KIND_POP_FRONT: begin
            if (empty) begin
              res_d.status = sqd_pkg::STAT_EMPTY;
            end else begin
              re      = 1'b1;
              raddr   = head_q;
              if (!before_q && cur_q == head_q) begin
                before_d = 1'b1;
              end
              head_d  = sqd_pkg::slot_add(head_q, sqd_pkg::cnt_t'(1));
              count_d = count_q - 1'b1;
              done_d  = 1'b0;
              state_d = ST_READ;
            end
          end
          sqd_pkg::KIND_PEEK_FIRST, sqd_pkg::KIND_PEEK_LAST: begin
            if (empty) begin
              res_d.status = sqd_pkg::STAT_EMPTY;
            end else begin
              re      = 1'b1;
              raddr   = (req_q.kind == sqd_pkg::KIND_PEEK_FIRST) ? head_q
                      : sqd_pkg::slot_add(head_q, count_q - 1'b1);
              done_d  = 1'b0;
              state_d = ST_READ;
            end
          end
          sqd_pkg::KIND_CONTAINS: begin
            if (!empty) begin
              re      = 1'b1;
              raddr   = head_q;
              idx_d   = '0;
              done_d  = 1'b0;
              state_d = ST_SCAN;
            end
          end
          sqd_pkg::KIND_CLEAR: begin
            head_d   = '0;
            count_d  = '0;
            cur_d    = '0;
            before_d = 1'b1;
          end
          sqd_pkg::KIND_REWIND: begin
            before_d  = 1'b1;
            res_d.flag = !empty;
          end
          sqd_pkg::KIND_NEXT: begin
            if (empty) begin
              res_d.status = sqd_pkg::STAT_EMPTY;
            end else if (!follows) begin
              res_d.status = sqd_pkg::STAT_NO_NEXT;
            end else begin
              cur_d    = sqd_pkg::slot_add(head_q, new_pos);
              before_d = 1'b0;
              re       = 1'b1;
              raddr    = cur_d;
              flag_d   = follows_after;
              done_d   = 1'b0;
              state_d  = ST_READ;
            end
          end
          default: ;
        endcase
        res_d.count = 5'(count_d);
      end
      ST_READ: begin
        res_d.read_word = 32'(rdata);
        res_d.flag      = flag_q;
        done_d          = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_SCAN: begin
        re    = 1'b1;
        raddr = sqd_pkg::slot_add(head_q, idx_nxt);
        if (rdata == key || idx_nxt >= count_q) begin
          res_d.flag = (rdata == key);
          done_d     = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          idx_d = idx_nxt;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      head_q   <= '0;
      count_q  <= '0;
      cur_q    <= '0;
      before_q <= 1'b1;
      idx_q    <= '0;
      flag_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      before_q <= before_d;
      idx_q    <= idx_d;
      flag_q   <= flag_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

@@ test/stack_queue_deque_tb.sv @@
// Self-checking testbench for stack_queue_deque: directed and random op beats,
// each result checked against an in-bench prediction of the ring store.
// Depends on sqd_pkg and the stack_queue_deque RTL.
`timescale 1ns / 100ps
`default_nettype none
module stack_queue_deque_tb;

  logic           clk_i   = 1'b0;
  logic           rst_ni  = 1'b0;
  logic           start_i = 1'b0;
  sqd_pkg::req_t  req_i   = '0;
  logic           busy_o;
  logic           done_o;
  sqd_pkg::res_t  res_o;

  sqd_pkg::res_t pending_results[$];
  int unsigned   mismatch_count = 0;
  bit            gaps_on        = 1'b1;

  // predicted ring store and iterator
  sqd_pkg::word_t ring_words[sqd_pkg::DEPTH];
  int unsigned    ring_head    = 0;
  int unsigned    ring_fill    = 0;
  int unsigned    iter_slot    = 0;
  bit             iter_at_start = 1'b1;

  stack_queue_deque i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit iter_has_next();
    int unsigned pos;
    if (iter_at_start) return ring_fill > 0;
    pos = (iter_slot + sqd_pkg::DEPTH - ring_head) % sqd_pkg::DEPTH;
    return pos + 1 < ring_fill;
  endfunction

  function automatic sqd_pkg::res_t predict_deque_op(sqd_pkg::req_t r);
    sqd_pkg::res_t o;
    o = '0;
    case (r.kind)
      sqd_pkg::KIND_PUSH_FRONT: begin
        if (ring_fill >= sqd_pkg::DEPTH) begin
          o.status = sqd_pkg::STAT_FULL;
        end else begin
          ring_head = (ring_head + sqd_pkg::DEPTH - 1) % sqd_pkg::DEPTH;
          ring_words[ring_head] = r.data_word;
          ring_fill++;
        end
      end
      sqd_pkg::KIND_PUSH_BACK: begin
        if (ring_fill >= sqd_pkg::DEPTH) begin
          o.status = sqd_pkg::STAT_FULL;
        end else begin
          ring_words[(ring_head + ring_fill) % sqd_pkg::DEPTH] = r.data_word;
          ring_fill++;
        end
      end
      sqd_pkg::KIND_POP_FRONT: begin
        if (ring_fill == 0) begin
          o.status = sqd_pkg::STAT_EMPTY;
        end else begin
          o.read_word = ring_words[ring_head];
          if (!iter_at_start && iter_slot == ring_head) iter_at_start = 1'b1;
          ring_head = (ring_head + 1) % sqd_pkg::DEPTH;
          ring_fill--;
        end
      end
      sqd_pkg::KIND_PEEK_FIRST: begin
        if (ring_fill == 0) o.status = sqd_pkg::STAT_EMPTY;
        else o.read_word = ring_words[ring_head];
      end
      sqd_pkg::KIND_PEEK_LAST: begin
        if (ring_fill == 0) o.status = sqd_pkg::STAT_EMPTY;
        else o.read_word = ring_words[(ring_head + ring_fill - 1) % sqd_pkg::DEPTH];
      end
      sqd_pkg::KIND_CONTAINS: begin
        for (int unsigned i = 0; i < ring_fill; i++) begin
          if (ring_words[(ring_head + i) % sqd_pkg::DEPTH] == r.data_word) begin
            o.flag = 1'b1;
            break;
          end
        end
      end
      sqd_pkg::KIND_CLEAR: begin
        ring_head     = 0;
        ring_fill     = 0;
        iter_slot     = 0;
        iter_at_start = 1'b1;
      end
      sqd_pkg::KIND_REWIND: begin
        iter_at_start = 1'b1;
        o.flag = ring_fill > 0;
      end
      sqd_pkg::KIND_NEXT: begin
        if (ring_fill == 0) begin
          o.status = sqd_pkg::STAT_EMPTY;
        end else if (!iter_has_next()) begin
          o.status = sqd_pkg::STAT_NO_NEXT;
        end else begin
          iter_slot     = iter_at_start ? ring_head : (iter_slot + 1) % sqd_pkg::DEPTH;
          iter_at_start = 1'b0;
          o.read_word   = ring_words[iter_slot];
          o.flag        = iter_has_next();
        end
      end
      default: ;
    endcase
    o.count = 5'(ring_fill);
    return o;
  endfunction

  // start stays high across back-to-back beats; lowered only for a gap
  task automatic send_op(logic [3:0] kind, sqd_pkg::word_t word);
    sqd_pkg::req_t r;
    r.kind      = kind;
    r.data_word = word;
    if (gaps_on && $urandom_range(99) < 11) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_results.push_back(predict_deque_op(r));
  endtask

  always @(posedge clk_i) begin : check_results
    sqd_pkg::res_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: %p", res_o);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_o.read_word !== want.read_word) begin
          $error("read_word: expected %h, got %h", want.read_word, res_o.read_word);
          mismatch_count++;
        end
        if (res_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_o.status);
          mismatch_count++;
        end
        if (res_o.flag !== want.flag) begin
          $error("flag: expected %0d, got %0d", want.flag, res_o.flag);
          mismatch_count++;
        end
        if (res_o.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, res_o.count);
          mismatch_count++;
        end
      end
    end
  end

  task automatic test_empty_store();
    send_op(sqd_pkg::KIND_POP_FRONT, '0);
    send_op(sqd_pkg::KIND_PEEK_FIRST, '0);
    send_op(sqd_pkg::KIND_PEEK_LAST, '0);
    send_op(sqd_pkg::KIND_NEXT, '0);
    send_op(sqd_pkg::KIND_CONTAINS, '0);
    send_op(4'hF, '1);
  endtask

  task automatic test_full_store();
    for (int i = 0; i < sqd_pkg::DEPTH; i++) begin
      send_op(i[0] ? sqd_pkg::KIND_PUSH_FRONT : sqd_pkg::KIND_PUSH_BACK,
              (i == 0) ? '0 : (i == 1) ? '1 : sqd_pkg::word_t'($urandom));
    end
    send_op(sqd_pkg::KIND_PUSH_FRONT, 32'hA5A5_A5A5);
    send_op(sqd_pkg::KIND_PUSH_BACK, 32'h5A5A_5A5A);
  endtask

  // popping the element under the iterator must rewind it
  task automatic test_iterator();
    send_op(sqd_pkg::KIND_REWIND, '0);
    send_op(sqd_pkg::KIND_NEXT, '0);
    send_op(sqd_pkg::KIND_CONTAINS, '1);
    send_op(sqd_pkg::KIND_POP_FRONT, '0);
    send_op(sqd_pkg::KIND_NEXT, '0);
    send_op(sqd_pkg::KIND_CLEAR, '0);
    send_op(sqd_pkg::KIND_REWIND, '0);
  endtask

  task automatic test_random_mix();
    int unsigned    issued;
    int unsigned    mode;
    int unsigned    push_pct;
    int unsigned    pop_pct;
    int unsigned    next_pct;
    int unsigned    roll;
    logic [3:0]     kind;
    sqd_pkg::word_t word;
    issued = 0;
    mode   = 0;
    while (issued < 2000) begin
      if (issued % 100 == 0) mode = $urandom_range(3);
      gaps_on = !(issued >= 800 && issued < 1200);
      case (mode)
        0:       begin push_pct = 55; pop_pct = 10; next_pct = 10; end
        1:       begin push_pct = 15; pop_pct = 45; next_pct = 10; end
        2:       begin push_pct = 25; pop_pct = 10; next_pct = 35; end
        default: begin push_pct = 35; pop_pct = 20; next_pct = 15; end
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        kind = $urandom_range(1) ? sqd_pkg::KIND_PUSH_FRONT : sqd_pkg::KIND_PUSH_BACK;
      end else if (roll < push_pct + pop_pct) begin
        kind = sqd_pkg::KIND_POP_FRONT;
      end else if (roll < push_pct + pop_pct + next_pct) begin
        kind = sqd_pkg::KIND_NEXT;
      end else begin
        roll = $urandom_range(99);
        if (roll < 20) kind = sqd_pkg::KIND_PEEK_FIRST;
        else if (roll < 40) kind = sqd_pkg::KIND_PEEK_LAST;
        else if (roll < 65) kind = sqd_pkg::KIND_CONTAINS;
        else if (roll < 88) kind = sqd_pkg::KIND_REWIND;
        else if (roll < 94) kind = sqd_pkg::KIND_CLEAR;
        else kind = 4'($urandom_range(9, 15));
      end
      // small values repeat, so searches hit duplicates
      word = ($urandom_range(3) == 0) ? sqd_pkg::word_t'($urandom_range(7))
                                      : sqd_pkg::word_t'($urandom);
      if (kind == sqd_pkg::KIND_CONTAINS && ring_fill > 0 && $urandom_range(1)) begin
        word = ring_words[(ring_head + $urandom_range(ring_fill - 1)) % sqd_pkg::DEPTH];
      end
      send_op(kind, word);
      if (kind <= sqd_pkg::KIND_NEXT) issued++;
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_store();
    test_full_store();
    test_iterator();
    test_random_mix();
    start_i <= 1'b0;
    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < 1000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d result beats never arrived", pending_results.size());
      mismatch_count++;
    end
    repeat (2 * sqd_pkg::DEPTH + 4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
